[sv/rotation_matrix_to_quaternion_unit_defines.svh]
// Assertion macros used by the checker file rmq_checker.sv.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// Check that a condition always leads to a consequence in the same cycle.
`define RMQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that an expression never holds.
`define RMQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("assertion failed");

`endif

[sv/rmq_pkg.sv]
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W          = 18;
    localparam int D_W           = 19;
    localparam int QW            = 18;
    localparam int SAT_MAX       = 131071;

    localparam logic [1:0] FIRST_W = 2'd0;
    localparam logic [1:0] FIRST_X = 2'd1;
    localparam logic [1:0] FIRST_Y = 2'd2;
    localparam logic [1:0] FIRST_Z = 2'd3;

    // control and side data that rides along the root pipeline
    typedef struct packed {
        logic                  valid;
        logic [1:0]            first;
        logic                  degen;
        logic signed [D_W-1:0] d_a;
        logic signed [D_W-1:0] d_b;
        logic signed [D_W-1:0] d_c;
    } t_side;

    // signed width of the trace and the root argument
    function automatic int arg_width(input int f);
        return ((f > 19) ? f : 19) + 3;
    endfunction

    // bits of the integer square root of arg << f
    function automatic int root_width(input int f);
        return (arg_width(f) - 1 + f + 1) / 2;
    endfunction

    // cycles from an accepted start to the result strobe
    function automatic int latency(input int f);
        return root_width(f) + QW + 3;
    endfunction

    // apply sign and saturate a quotient magnitude
    function automatic logic signed [IN_W-1:0] sat_part(input logic [QW-1:0] q,
                                                        input logic ovf,
                                                        input logic neg);
        logic signed [IN_W-1:0] res;
        if (neg) begin
            if (ovf || (q > 18'd131072)) begin
                res = 18'sh20000;
            end else begin
                res = IN_W'(-$signed({1'b0, q}));
            end
        end else begin
            if (ovf || q[QW-1]) begin
                res = 18'sh1FFFF;
            end else begin
                res = $signed(q);
            end
        end
        return res;
    endfunction

endpackage

[sv/rmq_front.sv]
module rmq_front #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_valid,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m11,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m12,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m13,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m21,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m22,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m23,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m31,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m32,
    input  logic signed [rmq_pkg::IN_W-1:0]                    i_m33,
    output logic signed [rmq_pkg::arg_width(FRAC_BITS)-1:0]    o_arg,
    output rmq_pkg::t_side                                     o_side
);
    import rmq_pkg::*;

    localparam int AW = arg_width(FRAC_BITS);
    localparam int TW = AW + 5;
    localparam logic signed [AW-1:0] C_ONE      = AW'(1) <<< FRAC_BITS;
    localparam logic signed [TW-1:0] C_NINE_ONE = TW'(9) <<< FRAC_BITS;

    logic signed [AW-1:0] e11, e22, e33, tr, n_arg, r_arg;
    logic signed [TW-1:0] tr25;
    t_side                n_side, r_side;

    assign e11 = AW'(i_m11);
    assign e22 = AW'(i_m22);
    assign e33 = AW'(i_m33);
    assign tr  = e11 + e22 + e33 + C_ONE;
    assign tr25 = (TW'(tr) <<< 4) + (TW'(tr) <<< 3) + TW'(tr);

    // pick the branch, root argument and off-diagonal terms
    always_comb begin
        n_side.valid = i_valid;
        n_side.degen = 1'b0;
        if (tr25 > C_NINE_ONE) begin
            n_side.first = FIRST_W;
            n_arg        = tr;
            n_side.d_a   = D_W'(i_m23) - D_W'(i_m32);
            n_side.d_b   = D_W'(i_m31) - D_W'(i_m13);
            n_side.d_c   = D_W'(i_m12) - D_W'(i_m21);
        end else if (i_m11 >= i_m22 && i_m11 >= i_m33) begin
            n_side.first = FIRST_X;
            n_arg        = C_ONE + e11 - e22 - e33;
            n_side.d_a   = D_W'(i_m12) + D_W'(i_m21);
            n_side.d_b   = D_W'(i_m13) + D_W'(i_m31);
            n_side.d_c   = D_W'(i_m23) - D_W'(i_m32);
        end else if (i_m22 >= i_m11 && i_m22 >= i_m33) begin
            n_side.first = FIRST_Y;
            n_arg        = C_ONE + e22 - e11 - e33;
            n_side.d_a   = D_W'(i_m12) + D_W'(i_m21);
            n_side.d_b   = D_W'(i_m23) + D_W'(i_m32);
            n_side.d_c   = D_W'(i_m31) - D_W'(i_m13);
        end else begin
            n_side.first = FIRST_Z;
            n_arg        = C_ONE + e33 - e11 - e22;
            n_side.d_a   = D_W'(i_m13) + D_W'(i_m31);
            n_side.d_b   = D_W'(i_m23) + D_W'(i_m32);
            n_side.d_c   = D_W'(i_m12) - D_W'(i_m21);
        end
    end

    // register the stage
    always_ff @(posedge i_clk) begin
        r_arg <= n_arg;
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else begin
            r_side <= n_side;
        end
    end

    assign o_arg  = r_arg;
    assign o_side = r_side;

endmodule

[sv/rmq_sqrt.sv]
module rmq_sqrt #(
    parameter int SW = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2*SW-1:0]  i_rad,
    input  rmq_pkg::t_side   i_side,
    output logic [SW-1:0]    o_root,
    output rmq_pkg::t_side   o_side
);
    import rmq_pkg::*;

    logic [SW:0]     r_rem  [SW];
    logic [SW-1:0]   r_root [SW];
    logic [2*SW-1:0] r_rad  [SW];
    t_side           r_side [SW];

    // one root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < SW; k++) begin : g_stage
        logic [SW:0]     p_rem;
        logic [SW-1:0]   p_root;
        logic [2*SW-1:0] p_rad;
        t_side           p_side;
        logic [SW+1:0]   shifted, trial, diff;
        logic            take;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
        end

        assign shifted = {p_rem[SW-1:0], p_rad[2*SW-1:2*SW-2]};
        assign trial   = {p_root, 2'b01};
        assign diff    = shifted - trial;
        assign take    = shifted >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= take ? diff[SW:0] : shifted[SW:0];
            r_root[k] <= {p_root[SW-2:0], take};
            r_rad[k]  <= {p_rad[2*SW-3:0], 2'b00};
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else begin
                r_side[k] <= p_side;
            end
        end
    end

    assign o_root = r_root[SW-1];
    assign o_side = r_side[SW-1];

endmodule

[sv/rmq_div.sv]
module rmq_div #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
    parameter int SW        = 18
) (
    input  logic                           i_clk,
    input  logic signed [rmq_pkg::D_W-1:0] i_d,
    input  logic [SW-1:0]                  i_s,
    output logic [rmq_pkg::QW-1:0]         o_q,
    output logic                           o_ovf,
    output logic                           o_neg
);
    import rmq_pkg::*;

    localparam int NW = D_W + FRAC_BITS + 1;
    localparam int DW = SW + 1;
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [D_W-1:0] mag;
    logic [CW-1:0]  num;
    logic [DW-1:0]  den;

    logic [CW-1:0]  r_rem [QW+1];
    logic [QW-1:0]  r_q   [QW+1];
    logic [DW-1:0]  r_den [QW+1];
    logic           r_ovf [QW+1];
    logic           r_neg [QW+1];

    // form the rounded numerator and the doubled root
    assign mag = i_d[D_W-1] ? D_W'(-i_d) : D_W'(i_d);
    assign num = (CW'(mag) << FRAC_BITS) + CW'(i_s);
    assign den = {i_s, 1'b0};

    always_ff @(posedge i_clk) begin
        r_rem[0] <= num;
        r_q[0]   <= '0;
        r_den[0] <= den;
        r_ovf[0] <= num >= (CW'(den) << QW);
        r_neg[0] <= i_d[D_W-1];
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int B = QW - k;
        logic [CW-1:0] trial;
        logic          take;

        assign trial = CW'(r_den[k-1]) << B;
        assign take  = r_rem[k-1] >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? r_rem[k-1] - trial : r_rem[k-1];
            r_q[k]   <= r_q[k-1] | (QW'(take) << B);
            r_den[k] <= r_den[k-1];
            r_ovf[k] <= r_ovf[k-1];
            r_neg[k] <= r_neg[k-1];
        end
    end

    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];
    assign o_neg = r_neg[QW];

endmodule

[sv/rotation_matrix_to_quaternion_unit.sv]
// Rotation matrix to quaternion converter, Shepperd branch selection.
// Input: nine signed Q3.14 elements i_m11..i_m33, taken at each rising edge
// where start is high and busy is low. busy is always low: a new matrix may
// enter in every cycle.
// Output: o_qw, o_qx, o_qy, o_qz (saturated), o_first_component and
// o_degenerate, shown for exactly one cycle with o_valid high.
// Pipeline: a branch selection register, then a square root stage for each
// of the root_width root bits, where root_width is half the width of the
// root radicand (arg << FRAC_BITS), then in each of the three parallel
// divider lanes a setup stage and a stage for each quotient bit, then the
// output register.
// Throughput: one matrix per cycle, results in acceptance order.
// Reset: synchronous, active low; clears all valid bits, so beats in flight
// are dropped and no strobe appears until new matrices arrive.
// The receiver cannot stall; each result must be taken in its strobe cycle.
module rotation_matrix_to_quaternion_unit #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m11,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m12,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m13,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m21,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m22,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m23,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m31,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m32,
    input  logic signed [rmq_pkg::IN_W-1:0] i_m33,
    output logic                            o_valid,
    output logic signed [rmq_pkg::IN_W-1:0] o_qw,
    output logic signed [rmq_pkg::IN_W-1:0] o_qx,
    output logic signed [rmq_pkg::IN_W-1:0] o_qy,
    output logic signed [rmq_pkg::IN_W-1:0] o_qz,
    output logic [1:0]                      o_first_component,
    output logic                            o_degenerate
);
    import rmq_pkg::*;

    localparam int AW   = arg_width(FRAC_BITS);
    localparam int SW   = root_width(FRAC_BITS);
    localparam int RADW = 2 * SW;

    logic signed [AW-1:0]   w_arg;
    t_side                  w_front, w_sq_in, w_sq_out;
    logic                   w_degen;
    logic [RADW-1:0]        w_rad;
    logic [SW-1:0]          w_root;
    logic [QW-1:0]          w_q_a, w_q_b, w_q_c;
    logic                   w_ovf_a, w_ovf_b, w_ovf_c, w_neg_a, w_neg_b, w_neg_c;

    t_side                  r_dly_side [QW+1];
    logic [SW-1:0]          r_dly_root [QW+1];

    logic [SW:0]            root_p1;
    logic [SW-1:0]          half;
    logic signed [IN_W-1:0] part_h, part_a, part_b, part_c;
    logic signed [IN_W-1:0] n_qw, n_qx, n_qy, n_qz;
    t_side                  d_side;

    logic                   r_valid, r_degenerate;
    logic [1:0]             r_first;
    logic signed [IN_W-1:0] r_qw, r_qx, r_qy, r_qz;

    assign busy = 1'b0;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_m11   (i_m11), .i_m12 (i_m12), .i_m13 (i_m13),
        .i_m21   (i_m21), .i_m22 (i_m22), .i_m23 (i_m23),
        .i_m31   (i_m31), .i_m32 (i_m32), .i_m33 (i_m33),
        .o_arg   (w_arg),
        .o_side  (w_front)
    );

    // flag a non-positive argument and feed zero to the root
    assign w_degen = w_arg[AW-1] | (w_arg == '0);
    assign w_rad   = w_degen ? '0 : (RADW'(w_arg[AW-2:0]) << FRAC_BITS);
    always_comb begin
        w_sq_in       = w_front;
        w_sq_in.degen = w_degen;
    end

    rmq_sqrt #(.SW(SW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rad   (w_rad),
        .i_side  (w_sq_in),
        .o_root  (w_root),
        .o_side  (w_sq_out)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_a (
        .i_clk (i_clk), .i_d (w_sq_out.d_a), .i_s (w_root),
        .o_q   (w_q_a), .o_ovf (w_ovf_a), .o_neg (w_neg_a)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_b (
        .i_clk (i_clk), .i_d (w_sq_out.d_b), .i_s (w_root),
        .o_q   (w_q_b), .o_ovf (w_ovf_b), .o_neg (w_neg_b)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_c (
        .i_clk (i_clk), .i_d (w_sq_out.d_c), .i_s (w_root),
        .o_q   (w_q_c), .o_ovf (w_ovf_c), .o_neg (w_neg_c)
    );

    // hold branch info and root alongside the divider lanes
    for (genvar k = 0; k <= QW; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (k == 0) begin
                r_dly_root[k] <= w_root;
            end else begin
                r_dly_root[k] <= r_dly_root[(k == 0) ? 0 : k-1];
            end
            if (!i_rst_n) begin
                r_dly_side[k].valid <= 1'b0;
            end else if (k == 0) begin
                r_dly_side[k] <= w_sq_out;
            end else begin
                r_dly_side[k] <= r_dly_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign d_side = r_dly_side[QW];

    // round the root half up and saturate
    assign root_p1 = {1'b0, r_dly_root[QW]} + 1'b1;
    assign half    = root_p1[SW:1];
    assign part_h  = (32'(half) > 32'(SAT_MAX)) ? 18'sh1FFFF : IN_W'(half);
    assign part_a  = sat_part(w_q_a, w_ovf_a, w_neg_a);
    assign part_b  = sat_part(w_q_b, w_ovf_b, w_neg_b);
    assign part_c  = sat_part(w_q_c, w_ovf_c, w_neg_c);

    // place the parts by branch
    always_comb begin
        case (d_side.first)
            FIRST_W: begin
                n_qw = part_h; n_qx = part_a; n_qy = part_b; n_qz = part_c;
            end
            FIRST_X: begin
                n_qw = part_c; n_qx = part_h; n_qy = part_a; n_qz = part_b;
            end
            FIRST_Y: begin
                n_qw = part_c; n_qx = part_a; n_qy = part_h; n_qz = part_b;
            end
            default: begin
                n_qw = part_c; n_qx = part_a; n_qy = part_b; n_qz = part_h;
            end
        endcase
        if (d_side.degen) begin
            n_qw = '0; n_qx = '0; n_qy = '0; n_qz = '0;
        end
    end

    // register the result beat
    always_ff @(posedge i_clk) begin
        r_qw         <= n_qw;
        r_qx         <= n_qx;
        r_qy         <= n_qy;
        r_qz         <= n_qz;
        r_first      <= d_side.first;
        r_degenerate <= d_side.degen;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= d_side.valid;
        end
    end

    assign o_valid           = r_valid;
    assign o_qw              = r_qw;
    assign o_qx              = r_qx;
    assign o_qy              = r_qy;
    assign o_qz              = r_qz;
    assign o_first_component = r_first;
    assign o_degenerate      = r_degenerate;

endmodule

[sv/rmq_checker.sv]
`include "rotation_matrix_to_quaternion_unit_defines.svh"

module rmq_checker #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            o_valid,
    input logic signed [rmq_pkg::IN_W-1:0] o_qw,
    input logic signed [rmq_pkg::IN_W-1:0] o_qx,
    input logic signed [rmq_pkg::IN_W-1:0] o_qy,
    input logic signed [rmq_pkg::IN_W-1:0] o_qz,
    input logic [1:0]                      o_first_component,
    input logic                            o_degenerate
);
    import rmq_pkg::*;

    localparam int LAT = latency(FRAC_BITS);

    // the pipeline never pushes back
    `RMQ_ASSERT_NEVER(a_no_busy, i_clk, i_rst_n, busy)

    // every strobe traces back to a start beat a fixed latency earlier
    `RMQ_ASSERT_IMPL(a_latency, i_clk, i_rst_n, o_valid, $past(start, LAT))

    // a degenerate beat carries all-zero parts and never the w branch
    `RMQ_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate,
        o_qw == '0 && o_qx == '0 && o_qy == '0 && o_qz == '0 && o_first_component != FIRST_W)

    // the part taken from the root is never negative
    `RMQ_ASSERT_IMPL(a_root_pos, i_clk, i_rst_n, o_valid && !o_degenerate,
        (o_first_component == FIRST_W && !o_qw[IN_W-1]) ||
        (o_first_component == FIRST_X && !o_qx[IN_W-1]) ||
        (o_first_component == FIRST_Y && !o_qy[IN_W-1]) ||
        (o_first_component == FIRST_Z && !o_qz[IN_W-1]))

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(.FRAC_BITS(FRAC_BITS)) u_rmq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_valid           (o_valid),
    .o_qw              (o_qw),
    .o_qx              (o_qx),
    .o_qy              (o_qy),
    .o_qz              (o_qz),
    .o_first_component (o_first_component),
    .o_degenerate      (o_degenerate)
);
